[rtl/i128alu_pkg.sv]
// Shared constants for the 128-bit ALU: word and port widths, opcodes.
// No dependencies; used by the top level and its port checker.
`default_nettype none

package i128alu_pkg;

    localparam int WORD_W   = 128;
    localparam int HALF_W   = 64;
    localparam int OP_W     = 4;
    localparam int SHAMT_W  = 8;
    localparam int STEP_W   = $clog2(WORD_W);

    // s_tdata: a_hi, a_lo, b_hi, b_lo, shift_amount (264 bits, whole bytes)
    localparam int S_TDATA_W = 4 * HALF_W + SHAMT_W;
    localparam int M_TDATA_W = 2 * HALF_W;

    typedef logic [OP_W-1:0] opcode_t;

    localparam opcode_t OP_ADD = 4'd0;
    localparam opcode_t OP_SUB = 4'd1;
    localparam opcode_t OP_MUL = 4'd2;
    localparam opcode_t OP_DIV = 4'd3;
    localparam opcode_t OP_AND = 4'd4;
    localparam opcode_t OP_OR  = 4'd5;
    localparam opcode_t OP_XOR = 4'd6;
    localparam opcode_t OP_NOT = 4'd7;
    localparam opcode_t OP_SHL = 4'd8;
    localparam opcode_t OP_SAR = 4'd9;

endpackage

`default_nettype wire

[rtl/int128_alu_booth_restoring_top.sv]
// Signed 128-bit ALU top level: sequencer around one shared 129-bit adder.
// Depends on i128alu_pkg for widths and opcodes.
`default_nettype none

// Signed 128-bit two's complement ALU on a stream interface. Each input item
// carries an opcode (s_tuser) and operands A = a_hi:a_lo, B = b_hi:b_lo plus a
// shift amount (s_tdata); each produces exactly one result item on m_tdata.
// Opcodes: 0 add, 1 sub, 2 mul, 3 div, 4 and, 5 or, 6 xor, 7 not A,
// 8 logical shift left of A, 9 arithmetic shift right of A; 10..15 give zero.
// Add, sub and mul wrap modulo 2^128; mul is radix-2 Booth keeping the low
// 128 bits. Div is signed, on magnitudes with 128 restoring steps, quotient
// negated when the signs differ; no remainder, and divide by zero gives an
// all-ones magnitude (so -1 or +1 after the sign fix-up). -2^127 / -1 wraps.
// Timing: the block takes one item at a time and drops s_tready while busy.
// Add, sub, logic and shifts go through ST_EXEC and ST_DONE before m_tvalid;
// mul runs its Booth steps one per cycle through the shared adder; div
// negates the operands, runs 128 restoring steps and fixes the quotient sign,
// all on the single 129-bit adder reused for every step. The result
// sits in an output register, so the next item is taken while it waits.
module int128_alu_booth_restoring_top (
    input  wire                               aclk,
    input  wire                               aresetn,
    // input items
    input  wire                               s_tvalid,
    output logic                              s_tready,
    // s_tdata, low bit up: a_hi[63:0], a_lo[127:64], b_hi[191:128],
    // b_lo[255:192], shift_amount[263:256]
    input  wire [i128alu_pkg::S_TDATA_W-1:0]  s_tdata,
    // s_tuser: opcode[3:0]
    input  wire [i128alu_pkg::OP_W-1:0]       s_tuser,
    // result items
    output logic                              m_tvalid,
    input  wire                               m_tready,
    // m_tdata, low bit up: result_hi[63:0], result_lo[127:64]
    output logic [i128alu_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int W  = i128alu_pkg::WORD_W;
    localparam int HW = i128alu_pkg::HALF_W;
    localparam int SW = i128alu_pkg::STEP_W;

    // sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EXEC = 3'd1;  // add, sub, logic and shift ops, A negation for div
    localparam logic [2:0] ST_NEGB = 3'd2;  // divisor magnitude
    localparam logic [2:0] ST_MUL  = 3'd3;  // Booth steps
    localparam logic [2:0] ST_DIV  = 3'd4;  // restoring steps
    localparam logic [2:0] ST_FIX  = 3'd5;  // quotient sign
    localparam logic [2:0] ST_DONE = 3'd6;  // wait for output register

    logic [2:0]                    state_reg, state_next;
    logic                          m_tvalid_reg, m_tvalid_next;
    i128alu_pkg::opcode_t          op_reg, op_next;
    logic [W:0]                    x_reg, x_next;     // Booth accumulator / remainder
    logic [W-1:0]                  q_reg, q_next;     // multiplier / quotient / result
    logic [W-1:0]                  m_reg, m_next;     // multiplicand / divisor
    logic                          qm1_reg, qm1_next; // Booth guard bit
    logic [SW-1:0]                 cnt_reg, cnt_next;
    logic                          sa_reg, sa_next;
    logic                          sb_reg, sb_next;
    logic [i128alu_pkg::SHAMT_W-1:0] sh_reg, sh_next;
    logic [W-1:0]                  res_reg, res_next;

    // shared adder: {cout, sum} = x + (y ^ sub) + sub
    logic [W:0]   add_x, add_y;
    logic         add_sub;
    logic [W+1:0] add_full;
    logic         s_fire, out_free, last_step, booth_op;
    logic [W:0]   div_rem;
    logic [W-1:0] shl_v, sar_v, logic_v;

    assign add_full = {1'b0, add_x} + {1'b0, add_y ^ {(W+1){add_sub}}}
                    + (W+2)'(add_sub);

    assign s_fire    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign last_step = (cnt_reg == SW'(W - 1));
    assign booth_op  = q_reg[0] ^ qm1_reg;
    assign div_rem   = {x_reg[W-1:0], q_reg[W-1]};

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {res_reg[HW-1:0], res_reg[W-1:HW]};

    // shifts: an amount of 128 or more fills completely
    always_comb begin
        shl_v = q_reg << sh_reg[SW-1:0];
        sar_v = W'($signed(q_reg) >>> sh_reg[SW-1:0]);
        if (sh_reg[i128alu_pkg::SHAMT_W-1:SW] != '0) begin
            shl_v = '0;
            sar_v = {W{q_reg[W-1]}};
        end
    end

    // adder operand select, from registered state only
    always_comb begin
        add_x   = {1'b0, q_reg};
        add_y   = {1'b0, m_reg};
        add_sub = (op_reg == i128alu_pkg::OP_SUB);
        unique case (state_reg)
            ST_EXEC: begin
                // |A| = 0 - A when negative
                if (op_reg == i128alu_pkg::OP_DIV) begin
                    add_x   = '0;
                    add_y   = {1'b0, q_reg};
                    add_sub = 1'b1;
                end
            end
            ST_NEGB: begin
                add_x   = '0;
                add_y   = {1'b0, m_reg};
                add_sub = 1'b1;
            end
            ST_MUL: begin
                // 10: subtract M, 01: add M, else pass
                add_x   = x_reg;
                add_y   = booth_op ? {m_reg[W-1], m_reg} : '0;
                add_sub = booth_op && q_reg[0];
            end
            ST_DIV: begin
                add_x   = div_rem;
                add_y   = {1'b0, m_reg};
                add_sub = 1'b1;
            end
            ST_FIX: begin
                add_x   = '0;
                add_y   = {1'b0, q_reg};
                add_sub = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // result of the ops finished in ST_EXEC, add and sub through the shared adder
    always_comb begin
        unique case (op_reg) inside
            i128alu_pkg::OP_ADD,
            i128alu_pkg::OP_SUB: logic_v = add_full[W-1:0];
            i128alu_pkg::OP_AND: logic_v = q_reg & m_reg;
            i128alu_pkg::OP_OR:  logic_v = q_reg | m_reg;
            i128alu_pkg::OP_XOR: logic_v = q_reg ^ m_reg;
            i128alu_pkg::OP_NOT: logic_v = ~q_reg;
            i128alu_pkg::OP_SHL: logic_v = shl_v;
            i128alu_pkg::OP_SAR: logic_v = sar_v;
            default:             logic_v = '0;
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg;
        op_next       = op_reg;
        x_next        = x_reg;
        q_next        = q_reg;
        m_next        = m_reg;
        qm1_next      = qm1_reg;
        cnt_next      = cnt_reg;
        sa_next       = sa_reg;
        sb_next       = sb_reg;
        sh_next       = sh_reg;
        res_next      = res_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    op_next    = s_tuser;
                    q_next     = {s_tdata[HW-1:0], s_tdata[2*HW-1:HW]};
                    m_next     = {s_tdata[3*HW-1:2*HW], s_tdata[4*HW-1:3*HW]};
                    sh_next    = s_tdata[i128alu_pkg::S_TDATA_W-1:4*HW];
                    sa_next    = s_tdata[HW-1];
                    sb_next    = s_tdata[3*HW-1];
                    x_next     = '0;
                    qm1_next   = 1'b0;
                    cnt_next   = '0;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (op_reg == i128alu_pkg::OP_MUL) begin
                    state_next = ST_MUL;
                end else if (op_reg == i128alu_pkg::OP_DIV) begin
                    if (sa_reg) begin
                        q_next = add_full[W-1:0];
                    end
                    state_next = ST_NEGB;
                end else begin
                    q_next     = logic_v;
                    state_next = ST_DONE;
                end
            end
            ST_NEGB: begin
                if (sb_reg) begin
                    m_next = add_full[W-1:0];
                end
                state_next = ST_DIV;
            end
            ST_MUL: begin
                // arithmetic shift right of accumulator and multiplier
                x_next   = {add_full[W], add_full[W:1]};
                q_next   = {add_full[0], q_reg[W-1:1]};
                qm1_next = q_reg[0];
                cnt_next = cnt_reg + 1'b1;
                if (last_step) begin
                    state_next = ST_DONE;
                end
            end
            ST_DIV: begin
                // carry out set means the shifted remainder is at least the divisor
                if (add_full[W+1]) begin
                    x_next = add_full[W:0];
                    q_next = {q_reg[W-2:0], 1'b1};
                end else begin
                    x_next = div_rem;
                    q_next = {q_reg[W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (last_step) begin
                    state_next = ST_FIX;
                end
            end
            ST_FIX: begin
                if (sa_reg ^ sb_reg) begin
                    q_next = add_full[W-1:0];
                end
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    res_next      = q_reg;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg  <= op_next;
        x_reg   <= x_next;
        q_reg   <= q_next;
        m_reg   <= m_next;
        qm1_reg <= qm1_next;
        cnt_reg <= cnt_next;
        sa_reg  <= sa_next;
        sb_reg  <= sb_next;
        sh_reg  <= sh_next;
        res_reg <= res_next;
    end

endmodule

`default_nettype wire

[rtl/i128alu_checker.sv]
// Port-level checks for the 128-bit ALU, bound to the top level.
// Depends on i128alu_pkg for port widths.
`default_nettype none

module i128alu_checker (
    input wire                               aclk,
    input wire                               aresetn,
    input wire                               s_tvalid,
    input wire                               s_tready,
    input wire                               m_tvalid,
    input wire                               m_tready,
    input wire [i128alu_pkg::M_TDATA_W-1:0]  m_tdata
);

    // one item at a time: busy straight after acceptance
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("s_tready high the cycle after an item was accepted");

    // a result waiting is held
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result item dropped or changed while stalled");

    // leaving the busy phase always posts a result
    a_result_on_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        ($rose(s_tready) && $past(aresetn)) |-> m_tvalid)
        else $error("block went idle without posting a result");

    // reset leaves the block empty and ready
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> (!m_tvalid && s_tready))
        else $error("block not idle and empty after reset");

endmodule

bind int128_alu_booth_restoring_top i128alu_checker u_i128alu_checker (.*);

`default_nettype wire
